/* hw/rtl/sevq_pkg.sv */
// shared types and codes for the sorted event queue
`timescale 1ns / 1ps
`default_nettype none

package sevq_pkg;

  // operation codes carried on the opcode field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/sevq_cell.sv */
// one slot of the shift-register queue: holds an entry and compares its time
`timescale 1ns / 1ps
`default_nettype none

module sevq_cell #(
  parameter int  TIME_BITS = 32,
  parameter int  ENT_BITS  = 52,
  parameter bit  IS_HEAD   = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire sevq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                 valid_i,
  input  wire logic [ENT_BITS-1:0]  new_i,
  input  wire logic [ENT_BITS-1:0]  left_i,
  input  wire logic                 left_past_i,
  input  wire logic [ENT_BITS-1:0]  right_i,
  input  wire logic                 front_i,
  output logic      [ENT_BITS-1:0]  ent_o,
  output logic                      past_o
);

  logic [ENT_BITS-1:0] ent_q, ent_d;
  logic                new_lt;
  logic                new_le;

  // new time strictly below the time held here
  assign new_lt = new_i[ENT_BITS-1 -: TIME_BITS] < ent_q[ENT_BITS-1 -: TIME_BITS];
  // new time at or below the time held here
  assign new_le = new_i[ENT_BITS-1 -: TIME_BITS] <= ent_q[ENT_BITS-1 -: TIME_BITS];

  // past: this slot sits at or after the insert point
  always_comb begin
    if (IS_HEAD) begin
      past_o = !valid_i || new_lt;
    end else begin
      past_o = !valid_i || new_le || front_i;
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins && past_o) begin
      ent_d = left_past_i ? left_i : new_i;
    end else if (ctrl_i.pop) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_event_queue.sv */
// sorted event queue: a row of compare-and-shift cells, head at cell zero
// the result of an item is registered and presented in the cycle after its transfer
// throughput: one insert or pop per cycle while no result is stalled; every cell compares and shifts in parallel
// in_ready_o drops only while a finished result waits on a stalled output
// reset clears the entry count and the result valid flag; slot contents are not reset
`timescale 1ns / 1ps
`default_nettype none

module sorted_event_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int ID_BITS     = 8,
  parameter int KIND_BITS   = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             opcode_i,
  input  wire logic [TIME_BITS-1:0]             event_time_i,
  input  wire logic [KIND_BITS-1:0]             event_kind_i,
  input  wire logic [ID_BITS-1:0]               source_id_i,
  input  wire logic [ID_BITS-1:0]               target_id_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output logic                                  out_valid_o,
  output logic [TIME_BITS-1:0]                  out_time_o,
  output logic [KIND_BITS-1:0]                  out_kind_o,
  output logic [ID_BITS-1:0]                    out_source_o,
  output logic [ID_BITS-1:0]                    out_target_o,
  output logic [1:0]                            status_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_count_o
);

  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_BITS = TIME_BITS + KIND_BITS + 2 * ID_BITS;

  logic [CW-1:0]       count_q, count_d;
  logic                res_valid_q;
  logic                xfer_in;
  logic                is_full, is_empty;
  logic [ENT_BITS-1:0] new_ent;
  logic [ENT_BITS-1:0] ent [QUEUE_DEPTH];
  logic                past [QUEUE_DEPTH];
  sevq_pkg::cell_ctrl_t ctrl;

  // output register payload
  logic                    ovalid_q, ovalid_d;
  logic [ENT_BITS-1:0]     oent_q, oent_d;
  sevq_pkg::status_e       status_q, status_d;
  logic [CW-1:0]           ofill_q;

  assign in_ready_o = !res_valid_q || res_ready_i;
  assign xfer_in    = in_valid_i && in_ready_o;
  assign is_full    = count_q == CW'(QUEUE_DEPTH);
  assign is_empty   = count_q == '0;
  assign new_ent    = {event_time_i, event_kind_i, source_id_i, target_id_i};

  assign ctrl.ins = xfer_in && (opcode_i == sevq_pkg::OP_INSERT) && !is_full;
  assign ctrl.pop = xfer_in && (opcode_i == sevq_pkg::OP_POP) && !is_empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ENT_BITS-1:0] left_ent, right_ent;
    logic                left_past;

    if (i == 0) begin : g_head
      assign left_ent  = new_ent;
      assign left_past = 1'b0;
    end else begin : g_body
      assign left_ent  = ent[i-1];
      assign left_past = past[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = ent[i];
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    sevq_cell #(
      .TIME_BITS (TIME_BITS),
      .ENT_BITS  (ENT_BITS),
      .IS_HEAD   (i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (CW'(i) < count_q),
      .new_i       (new_ent),
      .left_i      (left_ent),
      .left_past_i (left_past),
      .right_i     (right_ent),
      .front_i     (past[0]),
      .ent_o       (ent[i]),
      .past_o      (past[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    ovalid_d = 1'b0;
    oent_d   = '0;
    status_d = sevq_pkg::ST_OK;
    if (opcode_i == sevq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_d = sevq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = sevq_pkg::ST_EMPTY;
      end else begin
        ovalid_d = 1'b1;
        oent_d   = ent[0];
        count_d  = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (xfer_in) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_in) begin
      ovalid_q <= ovalid_d;
      oent_q   <= oent_d;
      status_q <= status_d;
      ofill_q  <= count_d;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign out_valid_o  = ovalid_q;
  assign out_time_o   = oent_q[ENT_BITS-1 -: TIME_BITS];
  assign out_kind_o   = oent_q[2*ID_BITS +: KIND_BITS];
  assign out_source_o = oent_q[ID_BITS +: ID_BITS];
  assign out_target_o = oent_q[0 +: ID_BITS];
  assign status_o     = status_q;
  assign fill_count_o = ofill_q;

endmodule

`default_nettype wire

/* hw/rtl/sevq_checker.sv */
// port-level checks for the sorted event queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sevq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        res_valid_o,
  input wire logic                        res_ready_i,
  input wire logic                        out_valid_o,
  input wire logic [1:0]                  status_o,
  input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_count_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // input side only stalls while a result is held
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> res_valid_o)
    else $error("input stalled with no pending result");

  // a returned event always comes with ok status
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == sevq_pkg::ST_OK)
    else $error("popped event with error status");

  // empty pop leaves the queue empty and returns nothing
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == sevq_pkg::ST_EMPTY |-> !out_valid_o && fill_count_o == '0)
    else $error("empty pop with entries or event");

  // a dropped insert only happens at full depth
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == sevq_pkg::ST_FULL |-> fill_count_o == CW'(QUEUE_DEPTH))
    else $error("insert dropped below full depth");

  // a stalled result is held
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(status_o) && $stable(fill_count_o))
    else $error("result changed while stalled");

endmodule

bind sorted_event_queue sevq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sevq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .out_valid_o  (out_valid_o),
  .status_o     (status_o),
  .fill_count_o (fill_count_o)
);

`default_nettype wire
